// File: hdl/htep_pkg.sv
// ----------------------------------------------------------------------------
// htep_pkg
// Shared types and codes of the Huffman table encoder and byte packer.
// ----------------------------------------------------------------------------
package htep_pkg;

   localparam int CMD_W        = 2;
   localparam int SYMBOL_W     = 8;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int BYTE_W       = 8;
   localparam int TOTAL_BITS_W = 48;
   localparam int PEND_W       = 7;
   localparam int PCNT_W       = 3;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   code_word;
      logic [LEN_W-1:0]    code_length;
   } htep_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]       packed_byte;
      logic                    byte_valid;
      logic                    last;
      logic [TOTAL_BITS_W-1:0] total_bits;
   } htep_rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_word;
      logic [LEN_W-1:0]  code_length;
   } htep_entry_type;

   typedef struct packed {
      logic                    byte_valid;
      logic                    last;
      logic [TOTAL_BITS_W-1:0] total_bits;
   } htep_job_ctl_type;

endpackage

// File: hdl/htep_code_table.sv
// ----------------------------------------------------------------------------
// htep_code_table
// Codebook memory, one entry per symbol, single address port, registered
// read. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module htep_code_table
   import htep_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256,
   localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic           rd_en,
   input  logic [AW-1:0]  addr,
   input  htep_entry_type wr_data,
   output htep_entry_type rd_data
);

   htep_entry_type mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   htep_entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: hdl/htep_byte_packer.sv
// ----------------------------------------------------------------------------
// htep_byte_packer
// Holds one left-aligned bit job and sends it out one byte per item,
// most significant byte first. Takes the next job as the last byte leaves.
// ----------------------------------------------------------------------------
module htep_byte_packer
   import htep_pkg::*;
#(
   parameter int ACC_W = 39,
   localparam int MAX_RESULTS = ACC_W / BYTE_W,
   localparam int RES_W = $clog2(MAX_RESULTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  logic [ACC_W-1:0] job_bits,
   input  logic [RES_W-1:0] job_count,
   input  htep_job_ctl_type job_ctl,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htep_rsp_type     rsp_data
);

   logic [ACC_W-1:0] bits_ff, bits_in;
   logic [RES_W-1:0] rem_ff, rem_in;
   htep_job_ctl_type ctl_ff, ctl_in;
   logic             take;

   assign rsp_valid = (rem_ff != '0);
   assign job_ready = !rsp_valid || (!rsp_stall && rem_ff == RES_W'(1));
   assign take      = job_valid && job_ready;

   always_comb begin
      bits_in = bits_ff;
      rem_in  = rem_ff;
      ctl_in  = ctl_ff;
      if (take) begin
         bits_in = job_bits;
         rem_in  = job_count;
         ctl_in  = job_ctl;
      end else if (rsp_valid && !rsp_stall) begin
         bits_in = bits_ff << BYTE_W;
         rem_in  = rem_ff - RES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      bits_ff <= bits_in;
      ctl_ff  <= ctl_in;
   end

   assign rsp_data.packed_byte = bits_ff[ACC_W-1 -: BYTE_W];
   assign rsp_data.byte_valid  = ctl_ff.byte_valid;
   assign rsp_data.last        = ctl_ff.last;
   assign rsp_data.total_bits  = ctl_ff.total_bits;

`ifndef SYNTHESIS
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      take |-> job_count != '0)
      else $error("packer took a job with no bytes");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= RES_W'(MAX_RESULTS))
      else $error("packer byte count beyond maximum");

   a_last_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ctl_ff.last) |-> rem_ff == RES_W'(1))
      else $error("stream end item is not a single byte job");
`endif

endmodule

// File: hdl/huffman_table_encode_pack_unit.sv
// ----------------------------------------------------------------------------
// huffman_table_encode_pack_unit
// Codebook Huffman encoder with MSB-first byte packing and flush.
// ----------------------------------------------------------------------------
// A load, or an encode that fills no byte, never reaches the byte packer; an
// encode that fills n bytes hands it an n-byte job (at most
// (7 + MAX_CODE_LEN) / 8, four at the default) and a flush a one-byte job.
// The result side carries one byte per cycle while rsp_stall is low. A result
// passes the registered codebook read and stage-one state, then the packer.
// The codebook reads as all zero right after reset, with no clearing pass.
module huffman_table_encode_pack_unit
   import htep_pkg::*;
#(
   parameter int MAX_CODE_LEN  = 32,
   parameter int ALPHABET_SIZE = 256,
   parameter int TOTAL_WIDTH   = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  htep_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output htep_rsp_type rsp_data
);

   localparam int AW          = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ACC_W       = MAX_CODE_LEN + PEND_W;
   localparam int CNT_W       = $clog2(ACC_W + 1);
   localparam int MAX_RESULTS = ACC_W / BYTE_W;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   logic req_accept, in_range;
   logic tbl_we, tbl_re;
   htep_entry_type wr_entry, rd_entry;
   logic [LEN_W-1:0]  ld_len;
   logic [CODE_W-1:0] ld_mask;

   logic             s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0] s1_cmd_ff, s1_cmd_in;
   logic [PEND_W-1:0]      pending_bits_ff, pending_bits_in;
   logic [PCNT_W-1:0]      pending_count_ff, pending_count_in;
   logic [TOTAL_WIDTH-1:0] bit_total_ff, bit_total_in;

   logic                   s1_flush, need_emit, s1_retire, s1_hold;
   logic [ACC_W-1:0]       enc_acc, enc_aligned;
   logic [CNT_W-1:0]       enc_total;
   logic [PEND_W-1:0]      enc_pend_mask;
   logic [TOTAL_WIDTH:0]   enc_sum;
   logic [TOTAL_WIDTH-1:0] enc_bit_total;
   logic [BYTE_W-1:0]      flush_byte;

   logic             job_valid, job_ready;
   logic [ACC_W-1:0] job_bits;
   logic [RES_W-1:0] job_count;
   htep_job_ctl_type job_ctl;

   // front end: codebook access
   assign req_stall  = s1_hold;
   assign req_accept = req_valid && !req_stall;
   assign in_range   = (32'(req_data.symbol) < ALPHABET_SIZE);
   assign tbl_we     = req_accept && in_range && (req_data.command == CMD_LOAD);
   assign tbl_re     = req_accept && in_range && (req_data.command == CMD_ENCODE);

   assign ld_len = (req_data.code_length > LEN_W'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : req_data.code_length;

   always_comb begin
      for (int i = 0; i < CODE_W; i++) begin
         ld_mask[i] = (i < int'(ld_len));
      end
   end

   assign wr_entry.code_word   = req_data.code_word & ld_mask;
   assign wr_entry.code_length = ld_len;

   htep_code_table #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_we),
      .rd_en   (tbl_re),
      .addr    (req_data.symbol[AW-1:0]),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   always_comb begin
      s1_valid_in = 1'b0;
      s1_cmd_in   = s1_cmd_ff;
      if (s1_hold) begin
         s1_valid_in = 1'b1;
      end else if (req_accept) begin
         if (tbl_re) begin
            s1_valid_in = 1'b1;
            s1_cmd_in   = CMD_ENCODE;
         end else if (req_data.command == CMD_FLUSH) begin
            s1_valid_in = 1'b1;
            s1_cmd_in   = CMD_FLUSH;
         end
      end
   end

   // accumulate stage
   assign s1_flush  = (s1_cmd_ff == CMD_FLUSH);
   assign enc_acc   = (ACC_W'(pending_bits_ff) << rd_entry.code_length)
                      | ACC_W'(rd_entry.code_word);
   assign enc_total = CNT_W'(pending_count_ff) + CNT_W'(rd_entry.code_length);
   assign enc_aligned   = enc_acc << (CNT_W'(ACC_W) - enc_total);
   assign enc_pend_mask = PEND_W'((8'd1 << enc_total[PCNT_W-1:0]) - 8'd1);

   assign enc_sum       = {1'b0, bit_total_ff} + (TOTAL_WIDTH+1)'(rd_entry.code_length);
   assign enc_bit_total = enc_sum[TOTAL_WIDTH] ? '1 : enc_sum[TOTAL_WIDTH-1:0];

   assign flush_byte = BYTE_W'({1'b0, pending_bits_ff} << (4'd8 - {1'b0, pending_count_ff}));

   assign need_emit = s1_flush || (enc_total >= CNT_W'(BYTE_W));
   assign s1_retire = s1_valid_ff && (!need_emit || job_ready);
   assign s1_hold   = s1_valid_ff && !s1_retire;

   always_comb begin
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      bit_total_in     = bit_total_ff;
      if (s1_retire) begin
         if (s1_flush) begin
            pending_bits_in  = '0;
            pending_count_in = '0;
            bit_total_in     = '0;
         end else begin
            pending_bits_in  = enc_acc[PEND_W-1:0] & enc_pend_mask;
            pending_count_in = enc_total[PCNT_W-1:0];
            bit_total_in     = enc_bit_total;
         end
      end
   end

   assign job_valid = s1_valid_ff && need_emit;
   assign job_bits  = s1_flush ? {flush_byte, {(ACC_W-BYTE_W){1'b0}}} : enc_aligned;
   assign job_count = s1_flush ? RES_W'(1) : RES_W'(enc_total >> 3);
   assign job_ctl.byte_valid = s1_flush ? (pending_count_ff != '0) : 1'b1;
   assign job_ctl.last       = s1_flush;
   assign job_ctl.total_bits = s1_flush ? TOTAL_BITS_W'(bit_total_ff)
                                        : TOTAL_BITS_W'(enc_bit_total);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s1_cmd_ff        <= CMD_ENCODE;
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         bit_total_ff     <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         s1_cmd_ff        <= s1_cmd_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         bit_total_ff     <= bit_total_in;
      end
   end

   htep_byte_packer #(
      .ACC_W (ACC_W)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_bits  (job_bits),
      .job_count (job_count),
      .job_ctl   (job_ctl),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_tbl_port: assert property (@(posedge clock) disable iff (reset)
      !(tbl_we && tbl_re))
      else $error("codebook read and write in one cycle");

   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      s1_hold |=> (s1_valid_ff && $stable(s1_cmd_ff) && $stable(pending_count_ff)))
      else $error("held item lost or state moved while held");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_retire && s1_flush) |=> (pending_count_ff == '0 && bit_total_ff == '0))
      else $error("flush did not restart the stream");
`endif

endmodule
